[rtl/pcha_pkg.sv]
`default_nettype none

package pcha_pkg;

	// Command codes
	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOFREE = 2'd1;
	localparam logic [1:0] ST_MANY   = 2'd2;

	// Cell operation codes
	localparam logic [1:0] OP_HOLD = 2'd0;
	localparam logic [1:0] OP_ADD  = 2'd1;
	localparam logic [1:0] OP_ROT  = 2'd2;

	localparam int PID_W = 22;
	localparam int CPU_W = 4;
	localparam int CFG_W = 5;

	typedef struct packed {
		logic             command;
		logic [PID_W-1:0] pid;
	} in_t;

	typedef struct packed {
		logic [PID_W-1:0] out_pid;
		logic [CPU_W-1:0] old_cpu;
		logic [CPU_W-1:0] new_cpu;
		logic [1:0]       status;
		logic             last;
	} out_t;

	// Broadcast from the sequencer to every cell
	typedef struct packed {
		logic [1:0]       op;
		logic             hit;
		logic [PID_W-1:0] pid;
	} cell_ctl_t;

endpackage

`default_nettype wire

[rtl/pcha_cell.sv]
`default_nettype none

module pcha_cell
	import pcha_pkg::*;
#(
	parameter int CW = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cell_ctl_t        ctl,
	input  wire logic [CW-1:0]    new_cpu,
	input  wire logic             prev_gt,
	input  wire logic             prev_valid,
	input  wire logic [PID_W-1:0] prev_pid,
	input  wire logic [CW-1:0]    prev_cpu,
	input  wire logic             next_valid,
	input  wire logic [PID_W-1:0] next_pid,
	input  wire logic [CW-1:0]    next_cpu,
	output logic                  valid,
	output logic [PID_W-1:0]      pid,
	output logic [CW-1:0]         cpu,
	output logic                  gt,
	output logic                  match
);

	logic             valid_q;
	logic [PID_W-1:0] pid_q;
	logic [CW-1:0]    cpu_q;

	// Compare own entry against the broadcast pid
	assign gt    = !valid_q || (pid_q > ctl.pid);
	assign match = valid_q && (pid_q == ctl.pid);

	assign valid = valid_q;
	assign pid   = pid_q;
	assign cpu   = cpu_q;

	// Valid flag: insert, shift up on insert, rotate down on walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctl.op)
				OP_ADD: begin
					if (!ctl.hit) begin
						if (prev_gt) begin
							valid_q <= prev_valid;
						end else if (gt) begin
							valid_q <= 1'b1;
						end
					end
				end
				OP_ROT: valid_q <= next_valid;
				default: ;
			endcase
		end
	end

	// Entry payload
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_ADD: begin
				if (ctl.hit) begin
					if (match) begin
						cpu_q <= new_cpu;
					end
				end else if (prev_gt) begin
					pid_q <= prev_pid;
					cpu_q <= prev_cpu;
				end else if (gt) begin
					pid_q <= ctl.pid;
					cpu_q <= new_cpu;
				end
			end
			OP_ROT: begin
				pid_q <= next_pid;
				cpu_q <= next_cpu;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

[rtl/pcha_ffind.sv]
`default_nettype none

module pcha_ffind
	import pcha_pkg::*;
#(
	parameter int N    = 16,
	parameter int CW   = 4,
	parameter int CNTW = 5
) (
	input  wire logic [N-1:0]    cpu_busy,
	input  wire logic [CNTW-1:0] eff_count,
	output logic                 found,
	output logic [CW-1:0]        idx
);

	// Pick the lowest free CPU below the effective count
	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int c = N - 1; c >= 0; c--) begin
			if (!cpu_busy[c] && (CNTW'(c) < eff_count)) begin
				found = 1'b1;
				idx   = CW'(c);
			end
		end
	end

endmodule

`default_nettype wire

[rtl/process_cpu_hopping_allocator.sv]
// Channel  | Signals                      | Transaction
// ---------+------------------------------+----------------------------------
// command  | start, busy, req             | start & !busy at a rising edge
// result   | done, rsp                    | each done carries one result, no stall
// config   | cfg_valid, cfg_ready, cfg_data| cfg_valid & cfg_ready
//
// An add registers its result in S_ADD; busy is high for a single cycle.
// A tick rotates the entry ring once: one result per valid entry in ascending
// pid order until a hop finds no free CPU, the head cell of the ring doing the hop.
// Reset clears busy bits, entry valid bits and the count, and sets the CPU
// count to min(MAX_CPUS, 16). The receiver cannot stall; cfg_ready is always high.
`default_nettype none

module process_cpu_hopping_allocator
	import pcha_pkg::*;
#(
	parameter int MAX_CPUS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire in_t              req,
	output logic                  done,
	output out_t                  rsp,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CFG_W-1:0] cfg_data
);

	localparam int N    = MAX_CPUS;
	localparam int CW   = (N > 1) ? $clog2(N) : 1;
	localparam int CNTW = $clog2(N + 1);
	localparam logic [CNTW-1:0] EFF_RST = CNTW'((N < 16) ? N : 16);
	localparam logic [CNTW-1:0] CNT_MAX = CNTW'(N);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_ADD  = 2'd1;
	localparam logic [1:0] S_TICK = 2'd2;

	logic [1:0]       state_q;
	logic [CW-1:0]    step_q;
	logic             stop_q;
	logic [PID_W-1:0] pid_q;
	logic [N-1:0]     busy_q;
	logic [CNTW-1:0]  cnt_q;
	logic [CNTW-1:0]  eff_q;
	logic             done_q;
	out_t             rsp_q;

	cell_ctl_t        ctl;
	logic [CW-1:0]    bind_cpu;
	logic             found;
	logic [CW-1:0]    free_idx;
	logic             hit;
	logic             bind_ok;
	logic             hop_act;
	logic             hop_ok;
	logic [CNTW-1:0]  cnt_new;

	logic [N-1:0]             c_valid;
	logic [N-1:0][PID_W-1:0]  c_pid;
	logic [N-1:0][CW-1:0]     c_cpu;
	logic [N-1:0]             c_gt;
	logic [N-1:0]             c_match;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign rsp       = rsp_q;

	pcha_ffind #(.N(N), .CW(CW), .CNTW(CNTW)) u_ffind (
		.cpu_busy  (busy_q),
		.eff_count (eff_q),
		.found     (found),
		.idx       (free_idx)
	);

	// Decode this cycle's work
	assign hit     = |c_match;
	assign bind_ok = (state_q == S_ADD) && found && (hit || (cnt_q != CNT_MAX));
	assign hop_act = (state_q == S_TICK) && !stop_q && (CNTW'(step_q) < cnt_q);
	assign hop_ok  = hop_act && found;
	assign cnt_new = hit ? cnt_q : cnt_q + CNTW'(1);
	assign bind_cpu = free_idx;

	always_comb begin
		ctl.hit = hit;
		ctl.pid = pid_q;
		ctl.op  = OP_HOLD;
		if (bind_ok) begin
			ctl.op = OP_ADD;
		end else if (state_q == S_TICK) begin
			ctl.op = OP_ROT;
		end
	end

	// Row of entry cells; the head wraps to the tail with its hop applied
	for (genvar k = 0; k < N; k++) begin : g_cell
		logic             pgt;
		logic             pv;
		logic [PID_W-1:0] pp;
		logic [CW-1:0]    pc;
		logic             nv;
		logic [PID_W-1:0] np;
		logic [CW-1:0]    nc;

		if (k == 0) begin : g_first
			assign pgt = 1'b0;
			assign pv  = 1'b0;
			assign pp  = '0;
			assign pc  = '0;
		end else begin : g_mid
			assign pgt = c_gt[k-1];
			assign pv  = c_valid[k-1];
			assign pp  = c_pid[k-1];
			assign pc  = c_cpu[k-1];
		end

		if (k == N - 1) begin : g_last
			assign nv = c_valid[0];
			assign np = c_pid[0];
			assign nc = hop_ok ? free_idx : c_cpu[0];
		end else begin : g_inner
			assign nv = c_valid[k+1];
			assign np = c_pid[k+1];
			assign nc = c_cpu[k+1];
		end

		pcha_cell #(.CW(CW)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_cpu    (bind_cpu),
			.prev_gt    (pgt),
			.prev_valid (pv),
			.prev_pid   (pp),
			.prev_cpu   (pc),
			.next_valid (nv),
			.next_pid   (np),
			.next_cpu   (nc),
			.valid      (c_valid[k]),
			.pid        (c_pid[k]),
			.cpu        (c_cpu[k]),
			.gt         (c_gt[k]),
			.match      (c_match[k])
		);
	end

	// Sequencer, busy bits, entry count and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			stop_q  <= 1'b0;
			busy_q  <= '0;
			cnt_q   <= '0;
			eff_q   <= EFF_RST;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				if (cfg_data < CFG_W'(2)) begin
					eff_q <= CNTW'(2);
				end else if (int'(cfg_data) > N) begin
					eff_q <= CNT_MAX;
				end else begin
					eff_q <= CNTW'(cfg_data);
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						step_q  <= '0;
						stop_q  <= 1'b0;
						state_q <= (req.command == CMD_TICK) ? S_TICK : S_ADD;
					end
				end
				S_ADD: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (bind_ok) begin
						busy_q <= busy_q | (N'(1) << bind_cpu);
						cnt_q  <= cnt_new;
					end
				end
				S_TICK: begin
					if (hop_act) begin
						done_q <= 1'b1;
						if (found) begin
							for (int c = 0; c < N; c++) begin
								busy_q[c] <= (busy_q[c] || (free_idx == CW'(c)))
									&& (c_cpu[0] != CW'(c));
							end
						end else begin
							stop_q <= 1'b1;
						end
					end
					step_q <= step_q + CW'(1);
					if (step_q == CW'(N - 1)) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Command pid and result register
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			pid_q <= req.pid;
		end
		if (state_q == S_ADD) begin
			rsp_q.out_pid <= pid_q;
			rsp_q.old_cpu <= '0;
			rsp_q.last    <= 1'b1;
			if (bind_ok) begin
				rsp_q.new_cpu <= CPU_W'(bind_cpu);
				rsp_q.status  <= (cnt_new >= eff_q) ? ST_MANY : ST_OK;
			end else begin
				rsp_q.new_cpu <= '0;
				rsp_q.status  <= ST_NOFREE;
			end
		end else if (hop_act) begin
			rsp_q.out_pid <= c_pid[0];
			rsp_q.old_cpu <= CPU_W'(c_cpu[0]);
			if (found) begin
				rsp_q.new_cpu <= CPU_W'(free_idx);
				rsp_q.status  <= ST_OK;
				rsp_q.last    <= (CNTW'(step_q) + CNTW'(1) == cnt_q);
			end else begin
				rsp_q.new_cpu <= '0;
				rsp_q.status  <= ST_NOFREE;
				rsp_q.last    <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/pcha_chk.sv]
`default_nettype none

module pcha_chk
	import pcha_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire in_t              req,
	input wire logic             done,
	input wire out_t             rsp,
	input wire logic             cfg_valid,
	input wire logic             cfg_ready,
	input wire logic [CFG_W-1:0] cfg_data
);

	// An accepted command always makes the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after accepting a command");

	// A failed placement ends the transaction
	a_nofree_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status == ST_NOFREE) |-> rsp.last && (rsp.new_cpu == '0))
		else $error("no-free result not final or has a cpu");

	// Too-many comes only from an add
	a_many_add: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status == ST_MANY) |-> rsp.last && (rsp.old_cpu == '0))
		else $error("too-many result malformed");

	// More results pending means the walk is still running
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.last |-> busy)
		else $error("non-final result while idle");

	// Hold the write data while a configuration write waits
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready || $stable(cfg_data))
		else $error("config write stalled with changing data");

endmodule

bind process_cpu_hopping_allocator pcha_chk u_pcha_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.req       (req),
	.done      (done),
	.rsp       (rsp),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_data  (cfg_data)
);

`default_nettype wire

[tb/process_cpu_hopping_allocator_test.sv]
`timescale 1ns / 100ps

module process_cpu_hopping_allocator_test;
	import pcha_pkg::*;

	localparam int CPU_SLOTS = 16;
	localparam int ITEMS_PER_PHASE = 64;

	typedef enum logic [1:0] {ROW_ADD, ROW_TICK, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic [PID_W-1:0] arg;
		bit               typed;
		out_t             want;
	} plan_row_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	in_t              req;
	logic             done;
	out_t             rsp;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data;

	// Shadow of the allocator state
	logic [CPU_SLOTS-1:0] cpu_taken;
	bit                   slot_used [CPU_SLOTS];
	logic [PID_W-1:0]     slot_pid [CPU_SLOTS];
	logic [CPU_W-1:0]     slot_cpu [CPU_SLOTS];
	logic [CFG_W-1:0]     cpu_count_q;

	out_t      placement_q[$];
	plan_row_t plan[$];
	int        mismatch_count;
	int        burst_left;

	process_cpu_hopping_allocator #(
		.MAX_CPUS(CPU_SLOTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL process_cpu_hopping_allocator");
		$finish;
	end

	// Clamp the programmed count into the legal range
	function automatic int usable_cpus();
		if (cpu_count_q < 2) return 2;
		if (cpu_count_q > CPU_SLOTS) return CPU_SLOTS;
		return int'(cpu_count_q);
	endfunction

	function automatic int lowest_free();
		int lim;
		lim = usable_cpus();
		for (int c = 0; c < lim; c++)
			if (!cpu_taken[c]) return c;
		return -1;
	endfunction

	// Bind a pid to the lowest free CPU and queue its placement
	function automatic void predict_bind(input logic [PID_W-1:0] pid);
		int   cpu;
		int   slot;
		int   vacant;
		int   used;
		out_t r;
		cpu = lowest_free();
		slot = -1;
		vacant = -1;
		for (int k = 0; k < CPU_SLOTS; k++) begin
			if (slot_used[k] && slot_pid[k] == pid) slot = k;
			if (!slot_used[k] && vacant < 0) vacant = k;
		end
		if (slot < 0) slot = vacant;
		r.out_pid = pid;
		r.old_cpu = '0;
		r.last = 1'b1;
		if (cpu < 0 || slot < 0) begin
			r.new_cpu = '0;
			r.status = ST_NOFREE;
		end else begin
			// old CPU of a rebound pid stays busy
			slot_used[slot] = 1'b1;
			slot_pid[slot] = pid;
			slot_cpu[slot] = CPU_W'(cpu);
			cpu_taken[cpu] = 1'b1;
			used = 0;
			for (int k = 0; k < CPU_SLOTS; k++)
				used += int'(slot_used[k]);
			r.new_cpu = CPU_W'(cpu);
			r.status = (used >= usable_cpus()) ? ST_MANY : ST_OK;
		end
		placement_q.push_back(r);
	endfunction

	// Walk entries in ascending pid order, hopping each to the lowest free CPU
	function automatic void predict_hop_walk();
		bit               started;
		bit               have_held;
		logic [PID_W-1:0] prev_pid;
		logic [CPU_W-1:0] from;
		int               sel;
		int               cpu;
		out_t             held;
		out_t             r;
		started = 1'b0;
		have_held = 1'b0;
		prev_pid = '0;
		for (int step = 0; step < CPU_SLOTS; step++) begin
			sel = -1;
			for (int k = 0; k < CPU_SLOTS; k++) begin
				if (!slot_used[k]) continue;
				if (started && slot_pid[k] <= prev_pid) continue;
				if (sel < 0 || slot_pid[k] < slot_pid[sel]) sel = k;
			end
			if (sel < 0) break;
			started = 1'b1;
			prev_pid = slot_pid[sel];
			from = slot_cpu[sel];
			cpu = lowest_free();
			r.out_pid = prev_pid;
			r.old_cpu = from;
			r.last = 1'b0;
			if (have_held) placement_q.push_back(held);
			have_held = 1'b1;
			if (cpu < 0) begin
				// stop the walk; this and later entries stay put
				r.new_cpu = '0;
				r.status = ST_NOFREE;
				held = r;
				break;
			end
			slot_cpu[sel] = CPU_W'(cpu);
			cpu_taken[cpu] = 1'b1;
			cpu_taken[from] = 1'b0;
			r.new_cpu = CPU_W'(cpu);
			r.status = ST_OK;
			held = r;
		end
		if (have_held) begin
			held.last = 1'b1;
			placement_q.push_back(held);
		end
	endfunction

	// Present one transaction and hold it until accepted; return queue index of its results
	task automatic issue(input in_t item, output int base);
		start <= 1'b1;
		req <= item;
		do @(posedge clk); while (busy);
		base = placement_q.size();
		if (item.command == CMD_TICK)
			predict_hop_walk();
		else
			predict_bind(item.pid);
	endtask

	// Bursts of back-to-back commands separated by random gaps
	task automatic pace();
		int gap;
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Drain, let a silent walk finish, then write the count
	task automatic set_cpu_count(input logic [CFG_W-1:0] value);
		start <= 1'b0;
		while (placement_q.size() != 0) @(posedge clk);
		repeat (CPU_SLOTS + 4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cpu_count_q = value;
	endtask

	// Check each result against the oldest expectation
	always @(posedge clk) begin
		out_t want;
		if (arst_n && done) begin
			if (placement_q.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result: pid %h old %0d new %0d status %0d last %0d",
					$time, rsp.out_pid, rsp.old_cpu, rsp.new_cpu, rsp.status, rsp.last);
			end else begin
				want = placement_q.pop_front();
				if (rsp !== want) begin
					mismatch_count++;
					$display("%0t: expected pid %h old %0d new %0d status %0d last %0d",
						$time, want.out_pid, want.old_cpu, want.new_cpu, want.status,
						want.last);
					$display("%0t: actual   pid %h old %0d new %0d status %0d last %0d",
						$time, rsp.out_pid, rsp.old_cpu, rsp.new_cpu, rsp.status, rsp.last);
				end
			end
		end
	end

	initial begin
		logic [CFG_W-1:0] phase_count [4];
		in_t              item;
		int               base;
		int               pick;
		int               occupied;
		int               wait_cycles;

		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		cpu_taken = '0;
		cpu_count_q = 5'd16;
		mismatch_count = 0;
		burst_left = 0;
		for (int k = 0; k < CPU_SLOTS; k++) begin
			slot_used[k] = 1'b0;
			slot_pid[k] = '0;
			slot_cpu[k] = '0;
		end
		phase_count = '{5'd16, 5'd7, 5'd12, 5'd2};

		// Directed rows; typed expectations where the outcome is obvious
		plan.push_back('{ROW_TICK, 22'h155555, 1'b0, '0});
		plan.push_back('{ROW_CFG, 22'd2, 1'b0, '0});
		plan.push_back('{ROW_ADD, 22'h000000, 1'b1,
			out_t'{22'h000000, 4'd0, 4'd0, ST_OK, 1'b1}});
		plan.push_back('{ROW_ADD, 22'h3FFFFF, 1'b1,
			out_t'{22'h3FFFFF, 4'd0, 4'd1, ST_MANY, 1'b1}});
		plan.push_back('{ROW_ADD, 22'h2AAAAA, 1'b1,
			out_t'{22'h2AAAAA, 4'd0, 4'd0, ST_NOFREE, 1'b1}});
		plan.push_back('{ROW_TICK, 22'h3FFFFF, 1'b1,
			out_t'{22'h000000, 4'd0, 4'd0, ST_NOFREE, 1'b1}});
		plan.push_back('{ROW_ADD, 22'h000000, 1'b1,
			out_t'{22'h000000, 4'd0, 4'd0, ST_NOFREE, 1'b1}});
		plan.push_back('{ROW_CFG, 22'd31, 1'b0, '0});
		plan.push_back('{ROW_ADD, 22'h155555, 1'b1,
			out_t'{22'h155555, 4'd0, 4'd2, ST_OK, 1'b1}});
		plan.push_back('{ROW_TICK, 22'h2AAAAA, 1'b0, '0});
		plan.push_back('{ROW_ADD, 22'h155555, 1'b0, '0});
		plan.push_back('{ROW_CFG, 22'd0, 1'b0, '0});
		plan.push_back('{ROW_ADD, 22'h000001, 1'b1,
			out_t'{22'h000001, 4'd0, 4'd0, ST_NOFREE, 1'b1}});
		plan.push_back('{ROW_TICK, 22'h000000, 1'b1,
			out_t'{22'h000000, 4'd3, 4'd0, ST_NOFREE, 1'b1}});
		plan.push_back('{ROW_CFG, 22'd5, 1'b0, '0});
		plan.push_back('{ROW_TICK, 22'h000000, 1'b0, '0});
		plan.push_back('{ROW_ADD, 22'h000001, 1'b0, '0});
		plan.push_back('{ROW_ADD, 22'h000002, 1'b1,
			out_t'{22'h000002, 4'd0, 4'd0, ST_NOFREE, 1'b1}});
		plan.push_back('{ROW_TICK, 22'h3FFFFF, 1'b0, '0});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				set_cpu_count(plan[i].arg[CFG_W-1:0]);
			end else begin
				item.command = (plan[i].kind == ROW_TICK) ? CMD_TICK : CMD_ADD;
				item.pid = plan[i].arg;
				issue(item, base);
				if (plan[i].typed) placement_q[base] = plan[i].want;
				pace();
			end
		end

		// Random phases: mostly fresh adds, some rebinds of live pids, frequent ticks
		foreach (phase_count[p]) begin
			set_cpu_count(phase_count[p]);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				occupied = 0;
				for (int k = 0; k < CPU_SLOTS; k++)
					occupied += int'(slot_used[k]);
				if ($urandom_range(0, 99) < 40) begin
					item.command = CMD_TICK;
					item.pid = PID_W'($urandom);
				end else if (occupied > 0 && $urandom_range(0, 99) < 15) begin
					pick = $urandom_range(0, CPU_SLOTS - 1);
					while (!slot_used[pick]) pick = (pick + 1) % CPU_SLOTS;
					item.command = CMD_ADD;
					item.pid = slot_pid[pick];
				end else begin
					item.command = CMD_ADD;
					item.pid = PID_W'($urandom_range(0, 22'h3FFFFF));
				end
				issue(item, base);
				pace();
			end
		end

		// Drain and settle
		start <= 1'b0;
		wait_cycles = 0;
		while (placement_q.size() != 0 && wait_cycles < 2000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (CPU_SLOTS + 4) @(posedge clk);
		if (placement_q.size() != 0) begin
			mismatch_count += placement_q.size();
			$display("%0t: %0d expected results never arrived", $time, placement_q.size());
		end
		if (mismatch_count == 0)
			$display("PASS process_cpu_hopping_allocator");
		else
			$display("FAIL process_cpu_hopping_allocator");
		$finish;
	end

endmodule
